### hdl/icmp_packet_classifier_rtt_macros.svh
// ----------------------------------------------------------------------------
// ICMP RTT classifier assertion macros
// Concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ICMP_PACKET_CLASSIFIER_RTT_MACROS_SVH
`define ICMP_PACKET_CLASSIFIER_RTT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define ICMPRTT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icmprtt: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define ICMPRTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icmprtt: next-cycle check failed");

`endif

### hdl/icmprtt_pkg.sv
// ----------------------------------------------------------------------------
// ICMP RTT classifier package
// Types, codes and helper functions shared by the classifier modules.
// ----------------------------------------------------------------------------
package icmprtt_pkg;

    // Width of the time stamp arithmetic; differences wrap modulo 2^TIME_BITS
    localparam int TIME_BITS = 32;
    localparam logic [31:0] RTT_MASK =
        (TIME_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << TIME_BITS) - 64'd1);

    // Request table geometry: one entry per sequence number, valid bit on top
    localparam int SEQ_W   = 16;
    localparam int STAMP_W = 32;
    localparam int ENTRY_W = STAMP_W + 1;
    localparam int DEPTH   = 1 << SEQ_W;

    // Frame byte counter saturates here
    localparam logic [6:0] POS_MAX = 7'd127;

    // Configuration register indexes
    localparam logic [1:0] CFG_LINK_MODE  = 2'd0;
    localparam logic [1:0] CFG_FAST_LIMIT = 2'd1;
    localparam logic [1:0] CFG_SLOW_LIMIT = 2'd2;

    // Link modes
    localparam logic [1:0] LINK_ETH    = 2'd0;
    localparam logic [1:0] LINK_COOKED = 2'd1;

    // Link header lengths
    localparam logic [6:0] LHDR_SHORT = 7'd14;
    localparam logic [6:0] LHDR_LONG  = 7'd16;

    // ICMP type codes
    localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] ICMP_UNREACH      = 8'd3;
    localparam logic [7:0] ICMP_QUENCH       = 8'd4;
    localparam logic [7:0] ICMP_ROUTE_CHANGE = 8'd5;
    localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] ICMP_TIME_EXC     = 8'd11;
    localparam logic [7:0] ICMP_PARAM_PROB   = 8'd12;

    // Other header constants
    localparam logic [3:0] IP_VERSION_4   = 4'd4;
    localparam logic [7:0] IP_PROTO_ICMP  = 8'd1;
    localparam logic [7:0] ETYPE_IPV4_HI  = 8'h08;
    localparam logic [7:0] ETYPE_IPV4_LO  = 8'h00;

    typedef enum logic [2:0] {
        KIND_REQUEST,
        KIND_REPLY,
        KIND_UNREACH,
        KIND_QUENCH,
        KIND_REDIRECT,
        KIND_TIME_EXC,
        KIND_PARAM,
        KIND_NONE
    } t_kind;

    typedef enum logic [1:0] {
        CLASS_FAST,
        CLASS_MEDIUM,
        CLASS_SLOW
    } t_rtt_class;

    // Parsed frame, one per kept frame end
    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [7:0]        code;
        logic [SEQ_W-1:0]  seq;
        logic [31:0]       detail;
        logic [31:0]       now;
    } t_event;

    // One result transaction
    typedef struct packed {
        t_kind             kind;
        logic [7:0]        code;
        logic [SEQ_W-1:0]  seq;
        logic              found;
        logic [31:0]       rtt;
        t_rtt_class        cls;
        logic [31:0]       detail;
    } t_result;

    // Table status toward the top level
    typedef struct packed {
        logic in_ready;
        logic clearing;
    } t_tbl_status;

    // Map an ICMP type to its message kind
    function automatic t_kind kind_of(input logic [7:0] type_byte);
        t_kind k;
        unique case (type_byte)
            ICMP_ECHO_REQUEST: k = KIND_REQUEST;
            ICMP_ECHO_REPLY:   k = KIND_REPLY;
            ICMP_UNREACH:      k = KIND_UNREACH;
            ICMP_QUENCH:       k = KIND_QUENCH;
            ICMP_ROUTE_CHANGE: k = KIND_REDIRECT;
            ICMP_TIME_EXC:     k = KIND_TIME_EXC;
            ICMP_PARAM_PROB:   k = KIND_PARAM;
            default:           k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

### hdl/icmp_packet_classifier_rtt.sv
// ----------------------------------------------------------------------------
// ICMP echo round-trip classifier
// Takes one captured frame byte per cycle with its tick stamp and gives one
// result transaction per kept ICMP frame; after its final byte it passes the
// lookup register and then the output register. After reset the block sweeps
// its 65536-entry request table with input ready low; configuration writes
// are taken during that time. Afterwards a byte is taken every cycle; input
// stalls only when a result still waits in the output register, a second one
// sits in the skid slot or is about to land there. The single RAM write port
// is shared by the sweep, request stores and reply clears; a frame with a
// result is at least 24 bytes long, so these never compete.
// ----------------------------------------------------------------------------
`include "icmp_packet_classifier_rtt_macros.svh"

module icmp_packet_classifier_rtt
    import icmprtt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_end_of_frame,
    input  logic [31:0] i_now_ticks,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_message_kind,
    output logic [7:0]  o_message_code,
    output logic [15:0] o_sequence_res,
    output logic        o_rtt_found,
    output logic [31:0] o_rtt_ticks,
    output logic [1:0]  o_rtt_class,
    output logic [31:0] o_detail_value
);

    logic [1:0]  r_link_mode;
    logic [31:0] r_fast_limit;
    logic [31:0] r_slow_limit;

    logic        in_accept;
    t_event      evt;
    t_result     res;
    t_tbl_status status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_mode  <= LINK_ETH;
            r_fast_limit <= 32'd50000;
            r_slow_limit <= 32'd200000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_LINK_MODE:  r_link_mode  <= i_cfg_wdata[1:0];
                CFG_FAST_LIMIT: r_fast_limit <= i_cfg_wdata;
                CFG_SLOW_LIMIT: r_slow_limit <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = status.in_ready;
    assign in_accept  = i_in_valid && status.in_ready;

    icmprtt_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_frame_byte   (i_frame_byte),
        .i_end_of_frame (i_end_of_frame),
        .i_now_ticks    (i_now_ticks),
        .i_link_mode    (r_link_mode),
        .o_event        (evt)
    );

    icmprtt_table u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_event      (evt),
        .i_fast_limit (r_fast_limit),
        .i_slow_limit (r_slow_limit),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_result     (res),
        .o_status     (status)
    );

    // Result fields
    assign o_message_kind = res.kind;
    assign o_message_code = res.code;
    assign o_sequence_res = res.seq;
    assign o_rtt_found    = res.found;
    assign o_rtt_ticks    = res.rtt;
    assign o_rtt_class    = res.cls;
    assign o_detail_value = res.detail;

    // Checks
    `ICMPRTT_ASSERT_NOW(a_no_accept_in_sweep, i_clk, i_rst_n, status.clearing, !o_in_ready)
    `ICMPRTT_ASSERT_NEXT(a_events_spaced, i_clk, i_rst_n, evt.valid, !evt.valid)
    `ICMPRTT_ASSERT_NOW(a_found_only_reply, i_clk, i_rst_n, o_out_valid && o_rtt_found, o_message_kind == KIND_REPLY)
    `ICMPRTT_ASSERT_NOW(a_unmatched_zero, i_clk, i_rst_n, o_out_valid && !o_rtt_found, o_rtt_ticks == 32'd0 && o_rtt_class == CLASS_FAST)

endmodule

### hdl/icmprtt_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module icmprtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/icmprtt_parser.sv
// ----------------------------------------------------------------------------
// ICMP RTT classifier frame parser
// Walks one frame byte per transaction, checks link and IP headers and
// captures the ICMP type, code, sequence and detail word.
// ----------------------------------------------------------------------------
module icmprtt_parser
    import icmprtt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_end_of_frame,
    input  logic [31:0] i_now_ticks,
    input  logic [1:0]  i_link_mode,
    output t_event      o_event
);

    logic [6:0]  r_pos,    n_pos;
    logic [5:0]  r_ihb,    n_ihb;
    logic        r_rej,    n_rej;
    logic [31:0] r_tcs,    n_tcs;
    logic [31:0] r_detail, n_detail;

    logic [6:0]  lhdr;
    logic [6:0]  start;
    logic [6:0]  off;
    logic        kept;
    t_kind       kind;

    // Next per-frame state from the current byte
    always_comb begin
        n_rej    = r_rej;
        n_ihb    = r_ihb;
        n_tcs    = r_tcs;
        n_detail = r_detail;
        lhdr     = (i_link_mode == LINK_COOKED) ? LHDR_LONG : LHDR_SHORT;

        // Link type check
        if (i_link_mode == LINK_ETH) begin
            if ((r_pos == 7'd12 && i_frame_byte != ETYPE_IPV4_HI) ||
                (r_pos == 7'd13 && i_frame_byte != ETYPE_IPV4_LO)) begin
                n_rej = 1'b1;
            end
        end else if (i_link_mode == LINK_COOKED) begin
            if ((r_pos == 7'd14 && i_frame_byte != ETYPE_IPV4_HI) ||
                (r_pos == 7'd15 && i_frame_byte != ETYPE_IPV4_LO)) begin
                n_rej = 1'b1;
            end
        end

        // IP version, header length and protocol
        if (r_pos == lhdr) begin
            if (i_frame_byte[7:4] != IP_VERSION_4) begin
                n_rej = 1'b1;
            end
            n_ihb = {i_frame_byte[3:0], 2'b00};
        end
        if (r_pos == 7'(lhdr + 7'd9) && i_frame_byte != IP_PROTO_ICMP) begin
            n_rej = 1'b1;
        end

        // ICMP header capture by offset from its start
        start = 7'(lhdr + {1'b0, n_ihb});
        off   = 7'(r_pos - start);
        if (r_pos >= lhdr && r_pos >= start) begin
            if (off == 7'd0) begin
                n_tcs[31:24] = i_frame_byte;
            end else if (off == 7'd1) begin
                n_tcs[23:16] = i_frame_byte;
            end else if (off == 7'd6) begin
                n_tcs[15:8] = i_frame_byte;
            end else if (off == 7'd7) begin
                n_tcs[7:0] = i_frame_byte;
            end
            if (off == 7'd4) begin
                n_detail[31:24] = i_frame_byte;
            end else if (off == 7'd5) begin
                n_detail[23:16] = i_frame_byte;
            end else if (off == 7'd6) begin
                n_detail[15:8] = i_frame_byte;
            end else if (off == 7'd7) begin
                n_detail[7:0] = i_frame_byte;
            end
        end

        // Saturating byte count
        n_pos = (r_pos < POS_MAX) ? 7'(r_pos + 7'd1) : POS_MAX;
    end

    // Frame end decision and event payload
    always_comb begin
        kind = kind_of(n_tcs[31:24]);
        kept = !n_rej && (n_pos >= 7'(lhdr + 7'd10)) &&
               ({1'b0, n_pos} >= 8'({1'b0, start} + 8'd8));

        o_event.valid = i_accept && i_end_of_frame && kept && (kind != KIND_NONE);
        o_event.kind  = kind;
        o_event.code  = n_tcs[23:16];
        o_event.seq   = n_tcs[15:0];
        o_event.now   = i_now_ticks;
        if (kind == KIND_REDIRECT) begin
            o_event.detail = n_detail;
        end else if (kind == KIND_PARAM) begin
            o_event.detail = {24'd0, n_detail[31:24]};
        end else begin
            o_event.detail = 32'd0;
        end
    end

    // Advance per byte, clear at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_ihb    <= '0;
            r_rej    <= 1'b0;
            r_tcs    <= '0;
            r_detail <= '0;
        end else if (i_accept) begin
            if (i_end_of_frame) begin
                r_pos    <= '0;
                r_ihb    <= '0;
                r_rej    <= 1'b0;
                r_tcs    <= '0;
                r_detail <= '0;
            end else begin
                r_pos    <= n_pos;
                r_ihb    <= n_ihb;
                r_rej    <= n_rej;
                r_tcs    <= n_tcs;
                r_detail <= n_detail;
            end
        end
    end

endmodule

### hdl/icmprtt_table.sv
// ----------------------------------------------------------------------------
// ICMP RTT classifier request table
// Holds echo request stamps per sequence number in a RAM, looks up and
// clears them on replies, classifies the delay and buffers results.
// ----------------------------------------------------------------------------
module icmprtt_table
    import icmprtt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_event      i_event,
    input  logic [31:0] i_fast_limit,
    input  logic [31:0] i_slow_limit,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output t_result     o_result,
    output t_tbl_status o_status
);

    logic               r_clearing;
    logic [SEQ_W-1:0]   r_clr_addr;
    logic               r_b_valid;
    t_event             r_b;
    logic               r_out_valid;
    t_result            r_out;
    logic               r_skid_valid;
    t_result            r_skid;

    logic               ram_we;
    logic [SEQ_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;

    logic               b_found;
    logic [31:0]        b_diff;
    t_result            b_res;
    logic               out_free;

    // Entry layout: valid bit above the stamp; cleared to zero after reset
    icmprtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (i_event.seq),
        .o_rdata (ram_rdata)
    );

    // Sweep the table once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= SEQ_W'(r_clr_addr + 1'b1);
            if (r_clr_addr == {SEQ_W{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Reply lookup in the cycle of the frame end
    assign ram_re = i_event.valid && (i_event.kind == KIND_REPLY);

    // Share the write port: sweep, reply clear, request store. Kept frames
    // are at least 24 bytes long, so a reply clear and a request store never
    // meet in one cycle and a lookup never follows a write to the same entry
    // in the cycle after it.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_b.seq;
        ram_wdata = '0;
        priority if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
        end else if (r_b_valid && b_found) begin
            ram_we    = 1'b1;
            ram_waddr = r_b.seq;
        end else if (i_event.valid && i_event.kind == KIND_REQUEST) begin
            ram_we    = 1'b1;
            ram_waddr = i_event.seq;
            ram_wdata = {1'b1, i_event.now};
        end else begin
            ram_we    = 1'b0;
        end
    end

    // Hold the frame end for the lookup cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= i_event.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_event.valid) begin
            r_b <= i_event;
        end
    end

    // Elapsed time and class from the stored stamp
    always_comb begin
        b_found     = (r_b.kind == KIND_REPLY) && ram_rdata[ENTRY_W-1];
        b_diff      = 32'(r_b.now - ram_rdata[STAMP_W-1:0]) & RTT_MASK;
        b_res.kind   = r_b.kind;
        b_res.code   = r_b.code;
        b_res.seq    = r_b.seq;
        b_res.detail = r_b.detail;
        b_res.found  = b_found;
        if (!b_found) begin
            b_res.rtt = 32'd0;
            b_res.cls = CLASS_FAST;
        end else begin
            b_res.rtt = b_diff;
            if (b_diff < i_fast_limit) begin
                b_res.cls = CLASS_FAST;
            end else if (b_diff < i_slow_limit) begin
                b_res.cls = CLASS_MEDIUM;
            end else begin
                b_res.cls = CLASS_SLOW;
            end
        end
    end

    // Output register with a skid slot behind it
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= r_b_valid;
            end else begin
                r_out_valid  <= r_b_valid;
            end
        end else if (r_b_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (r_b_valid) begin
                    r_skid <= b_res;
                end
            end else if (r_b_valid) begin
                r_out <= b_res;
            end
        end else if (r_b_valid) begin
            r_skid <= b_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // Stall input during the sweep or when no slot is left for a result
    assign o_status.clearing = r_clearing;
    assign o_status.in_ready = !r_clearing && !r_skid_valid &&
                               !(r_b_valid && r_out_valid && !i_out_ready);

endmodule
